/* sv/ps2h_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ps2h_pkg;

    localparam int CfgWidth      = 16;
    localparam int CfgIndexWidth = 2;

    localparam logic [CfgIndexWidth-1:0] CFG_RX_TIMEOUT    = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_TX_TIMEOUT    = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_INHIBIT_TICKS = 2'd2;

    localparam logic [CfgWidth-1:0] RX_TIMEOUT_RESET    = 16'd224;
    localparam logic [CfgWidth-1:0] TX_TIMEOUT_RESET    = 16'd640;
    localparam logic [CfgWidth-1:0] INHIBIT_TICKS_RESET = 16'd100;

    localparam logic COMMAND_SAMPLE = 1'b0;
    localparam logic COMMAND_SEND   = 1'b1;

    typedef struct packed {
        logic [CfgWidth-1:0] rx_timeout;
        logic [CfgWidth-1:0] tx_timeout;
        logic [CfgWidth-1:0] inhibit_ticks;
    } ps2h_cfg_t;

    typedef struct packed {
        logic       clock_drive_low;
        logic       data_drive_low;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       rx_error;
        logic       tx_done;
        logic       tx_error;
        logic       busy_res;
    } ps2h_result_t;

endpackage

`default_nettype wire

/* sv/ps2h_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module ps2h_cfg_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [ps2h_pkg::CfgIndexWidth-1:0]  cfg_index,
    input  wire logic [ps2h_pkg::CfgWidth-1:0]       cfg_wdata,
    output ps2h_pkg::ps2h_cfg_t                      cfg
);

    ps2h_pkg::ps2h_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rx_timeout    <= ps2h_pkg::RX_TIMEOUT_RESET;
            cfg_reg.tx_timeout    <= ps2h_pkg::TX_TIMEOUT_RESET;
            cfg_reg.inhibit_ticks <= ps2h_pkg::INHIBIT_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ps2h_pkg::CFG_RX_TIMEOUT:    cfg_reg.rx_timeout    <= cfg_wdata;
                ps2h_pkg::CFG_TX_TIMEOUT:    cfg_reg.tx_timeout    <= cfg_wdata;
                ps2h_pkg::CFG_INHIBIT_TICKS: cfg_reg.inhibit_ticks <= cfg_wdata;
                default:                     ;  // drop writes to unused indexes
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* sv/ps2h_frame_fsm.sv */
`timescale 1ns / 1ps
`default_nettype none

module ps2h_frame_fsm #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire ps2h_pkg::ps2h_cfg_t   cfg,
    input  wire logic                  command,
    input  wire logic                  clock_line,
    input  wire logic                  data_line,
    input  wire logic [7:0]            send_byte,
    output ps2h_pkg::ps2h_result_t     result
);

    localparam int CmpW = (COUNT_BITS > ps2h_pkg::CfgWidth) ? COUNT_BITS : ps2h_pkg::CfgWidth;
    localparam logic [3:0] RX_PARITY_BIT = 4'd8;
    localparam logic [3:0] TX_LAST_EDGE  = 4'd11;
    localparam logic [3:0] TX_PARITY_BIT = 4'd9;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RX,
        PH_INHIBIT,
        PH_TX
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic                  last_clock_reg, last_clock_next;
    logic [3:0]            bit_index_reg, bit_index_next;
    logic [8:0]            shift_data_reg, shift_data_next;
    logic                  parity_acc_reg, parity_acc_next;
    logic [COUNT_BITS-1:0] phase_ticks_reg, phase_ticks_next;

    logic            changed;
    logic            fall;
    logic            ticks_full;
    logic [CmpW-1:0] ticks_ext;
    logic            rx_expired;
    logic            tx_expired;
    logic            inhibit_over;
    logic [3:0]      tx_bit_sel;

    assign changed      = clock_line != last_clock_reg;
    assign fall         = last_clock_reg && !clock_line;
    assign ticks_full   = &phase_ticks_reg;
    assign ticks_ext    = CmpW'(phase_ticks_reg);
    assign rx_expired   = !changed && (ticks_ext >= CmpW'(cfg.rx_timeout) || ticks_full);
    assign tx_expired   = !changed && (ticks_ext >= CmpW'(cfg.tx_timeout) || ticks_full);
    assign inhibit_over = ticks_ext >= CmpW'(cfg.inhibit_ticks) || ticks_full;

    always_comb
    begin
        phase_next       = phase_reg;
        bit_index_next   = bit_index_reg;
        shift_data_next  = shift_data_reg;
        parity_acc_next  = parity_acc_reg;
        phase_ticks_next = phase_ticks_reg;
        last_clock_next  = clock_line;
        result           = '0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (command == ps2h_pkg::COMMAND_SEND)
                begin
                    phase_next       = PH_INHIBIT;
                    shift_data_next  = {~(^send_byte), send_byte};
                    bit_index_next   = '0;
                    phase_ticks_next = COUNT_BITS'(1);
                end
                else if (fall)
                begin
                    phase_next       = PH_RX;
                    bit_index_next   = '0;
                    shift_data_next  = '0;
                    parity_acc_next  = 1'b0;
                    phase_ticks_next = '0;
                end
            end
            PH_RX:
            begin
                if (rx_expired)
                begin
                    result.rx_error  = 1'b1;
                    phase_next       = PH_IDLE;
                    bit_index_next   = '0;
                    parity_acc_next  = 1'b0;
                    phase_ticks_next = '0;
                end
                else
                begin
                    phase_ticks_next = changed ? '0 : phase_ticks_reg + COUNT_BITS'(1);
                    if (fall)
                    begin
                        if (bit_index_reg < RX_PARITY_BIT)
                        begin
                            shift_data_next[bit_index_reg[2:0]] =
                                shift_data_reg[bit_index_reg[2:0]] | data_line;
                            parity_acc_next = parity_acc_reg ^ data_line;
                            bit_index_next  = bit_index_reg + 4'd1;
                        end
                        else if (bit_index_reg == RX_PARITY_BIT)
                        begin
                            parity_acc_next = parity_acc_reg ^ data_line;
                            bit_index_next  = bit_index_reg + 4'd1;
                        end
                        else
                        begin
                            // stop bit: parity accumulator already holds the parity bit
                            if (parity_acc_reg && data_line)
                            begin
                                result.rx_valid = 1'b1;
                                result.rx_data  = shift_data_reg[7:0];
                            end
                            else
                            begin
                                result.rx_error = 1'b1;
                            end
                            phase_next       = PH_IDLE;
                            bit_index_next   = '0;
                            parity_acc_next  = 1'b0;
                            phase_ticks_next = '0;
                        end
                    end
                end
            end
            PH_INHIBIT:
            begin
                if (inhibit_over)
                begin
                    phase_next       = PH_TX;
                    bit_index_next   = '0;
                    phase_ticks_next = '0;
                end
                else
                begin
                    phase_ticks_next = phase_ticks_reg + COUNT_BITS'(1);
                end
            end
            PH_TX:
            begin
                if (tx_expired)
                begin
                    result.tx_error  = 1'b1;
                    phase_next       = PH_IDLE;
                    bit_index_next   = '0;
                    parity_acc_next  = 1'b0;
                    phase_ticks_next = '0;
                end
                else
                begin
                    phase_ticks_next = changed ? '0 : phase_ticks_reg + COUNT_BITS'(1);
                    if (fall)
                    begin
                        bit_index_next = bit_index_reg + 4'd1;
                        if (bit_index_next >= TX_LAST_EDGE)
                        begin
                            result.tx_done   = 1'b1;
                            phase_next       = PH_IDLE;
                            bit_index_next   = '0;
                            parity_acc_next  = 1'b0;
                            phase_ticks_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // line drive follows the state after this tick
        tx_bit_sel = bit_index_next - 4'd1;
        if (phase_next == PH_TX)
        begin
            if (bit_index_next == 4'd0)
                result.data_drive_low = 1'b1;
            else if (bit_index_next <= TX_PARITY_BIT)
                result.data_drive_low = ~shift_data_next[tx_bit_sel];
        end
        result.clock_drive_low = phase_next == PH_INHIBIT;
        result.busy_res        = phase_next != PH_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            last_clock_reg  <= 1'b1;
            bit_index_reg   <= '0;
            shift_data_reg  <= '0;
            parity_acc_reg  <= 1'b0;
            phase_ticks_reg <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            last_clock_reg  <= last_clock_next;
            bit_index_reg   <= bit_index_next;
            shift_data_reg  <= shift_data_next;
            parity_acc_reg  <= parity_acc_next;
            phase_ticks_reg <= phase_ticks_next;
        end
    end

    rx_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_RX |-> bit_index_reg <= 4'd9)
        else $error("receive bit index out of range");

    tx_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TX |-> bit_index_reg < TX_LAST_EDGE)
        else $error("transmit bit index out of range");

    idle_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> bit_index_reg == 4'd0 && !parity_acc_reg)
        else $error("idle entered without clearing frame state");

    hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(phase_ticks_reg))
        else $error("frame state moved without an accepted beat");

endmodule

`default_nettype wire

/* sv/ps2h_out_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module ps2h_out_stage (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire ps2h_pkg::ps2h_result_t result_in,
    output logic                        full,
    input  wire logic                   take,
    output ps2h_pkg::ps2h_result_t      result_out
);

    logic                   full_reg;
    ps2h_pkg::ps2h_result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (load)
            full_reg <= 1'b1;
        else if (take)
            full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_in;
    end

    assign full       = full_reg;
    assign result_out = result_reg;

endmodule

`default_nettype wire

/* sv/ps2_host_frame_transceiver.sv */
// PS/2 host frame transceiver.
// Input channel (in_valid/in_ready): one beat per tick. command = 0 is a line
// sample (clock_line, data_line); command = 1 asks to send send_byte and is
// treated as a plain sample while a frame is in progress.
// Output channel (out_valid/out_ready): exactly one result beat per input beat,
// in order, showing the line drives and status after that tick.
// The result is registered and shows in the cycle after its input beat.
// Throughput: one beat per cycle while each result is taken; the frame state
// advances in a single pass of logic, and the output register lets a new beat
// in while the last result is taken in the same cycle.
// Stall: while a result waits untaken, in_ready is low and the state holds.
// Reset: frame logic goes idle, last clock level taken as high, no result
// pending, line drives not reset; rx_timeout = 224, tx_timeout = 640,
// inhibit_ticks = 100. Write cfg_we/cfg_index/cfg_wdata only while idle.
`timescale 1ns / 1ps
`default_nettype none

module ps2_host_frame_transceiver #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               command,
    input  wire logic                               clock_line,
    input  wire logic                               data_line,
    input  wire logic [7:0]                         send_byte,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    clock_drive_low,
    output logic                                    data_drive_low,
    output logic                                    rx_valid,
    output logic [7:0]                              rx_data,
    output logic                                    rx_error,
    output logic                                    tx_done,
    output logic                                    tx_error,
    output logic                                    busy_res,
    input  wire logic                               cfg_we,
    input  wire logic [ps2h_pkg::CfgIndexWidth-1:0] cfg_index,
    input  wire logic [ps2h_pkg::CfgWidth-1:0]      cfg_wdata
);

    ps2h_pkg::ps2h_cfg_t    cfg;
    ps2h_pkg::ps2h_result_t result_next;
    ps2h_pkg::ps2h_result_t result;
    logic                   full;
    logic                   step;

    assign in_ready = !full || out_ready;
    assign step     = in_valid && in_ready;

    ps2h_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ps2h_frame_fsm #(
        .COUNT_BITS (COUNT_BITS)
    ) u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .cfg        (cfg),
        .command    (command),
        .clock_line (clock_line),
        .data_line  (data_line),
        .send_byte  (send_byte),
        .result     (result_next)
    );

    ps2h_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .result_in  (result_next),
        .full       (full),
        .take       (out_ready),
        .result_out (result)
    );

    assign out_valid       = full;
    assign clock_drive_low = result.clock_drive_low;
    assign data_drive_low  = result.data_drive_low;
    assign rx_valid        = result.rx_valid;
    assign rx_data         = result.rx_data;
    assign rx_error        = result.rx_error;
    assign tx_done         = result.tx_done;
    assign tx_error        = result.tx_error;
    assign busy_res        = result.busy_res;

    rx_status_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(rx_valid && rx_error) && (rx_valid || rx_data == 8'd0))
        else $error("receive status inconsistent");

    finish_means_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (tx_done || tx_error || rx_valid || rx_error) |-> !busy_res)
        else $error("frame ended but block still busy");

    drive_means_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (clock_drive_low || data_drive_low) |-> busy_res
            && !(clock_drive_low && data_drive_low))
        else $error("line drive outside a frame");

    result_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted beat produced no result");

endmodule

`default_nettype wire
